@@ hdl/selective_ack_message_validator_macros.svh @@
// Assertion macros for the selective-ack message validator.
// Used by the top level; define NO_ASSERTIONS to drop them.
`ifndef SELECTIVE_ACK_MESSAGE_VALIDATOR_MACROS_SVH
`define SELECTIVE_ACK_MESSAGE_VALIDATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SAMV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SAMV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SAMV_ASSERT(label, prop, msg)
`define SAMV_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ hdl/samv_pkg.sv @@
// Types and constants for the selective-ack message validator.
// No dependencies.
package samv_pkg;

	localparam int unsigned FIXED_LEN = 22;
	localparam logic [16:0] POS_SAT = 17'h10000;

	localparam logic [4:0] RSN_OK         = 5'd0;
	localparam logic [4:0] RSN_TRUNC      = 5'd1;
	localparam logic [4:0] RSN_VERSION    = 5'd2;
	localparam logic [4:0] RSN_FLAGS      = 5'd3;
	localparam logic [4:0] RSN_COUNT      = 5'd4;
	localparam logic [4:0] RSN_HDR_LEN    = 5'd5;
	localparam logic [4:0] RSN_MSG_LEN    = 5'd6;
	localparam logic [4:0] RSN_CRC        = 5'd7;
	localparam logic [4:0] RSN_INDEX      = 5'd8;
	localparam logic [4:0] RSN_SPAN_ZERO  = 5'd9;
	localparam logic [4:0] RSN_OFFSET     = 5'd10;
	localparam logic [4:0] RSN_OVERFLOW   = 5'd11;
	localparam logic [4:0] RSN_WIDTH      = 5'd12;
	localparam logic [4:0] RSN_SLOT_CAP   = 5'd13;
	localparam logic [4:0] RSN_PADDING    = 5'd14;
	localparam logic [4:0] RSN_EPOCH_ZERO = 5'd15;
	localparam logic [4:0] RSN_SESSION    = 5'd16;
	localparam logic [4:0] RSN_EPOCH      = 5'd17;
	localparam logic [4:0] RSN_NEGOT      = 5'd18;
	localparam logic [4:0] RSN_SERIAL     = 5'd19;
	localparam logic [4:0] RSN_START      = 5'd20;

	localparam logic [2:0] REG_SESSION   = 3'd0;
	localparam logic [2:0] REG_EPOCH     = 3'd1;
	localparam logic [2:0] REG_NEGOT     = 3'd2;
	localparam logic [2:0] REG_SERIAL    = 3'd3;
	localparam logic [2:0] REG_START     = 3'd4;
	localparam logic [2:0] REG_SLOT_CAP  = 3'd5;
	localparam logic [2:0] REG_BATCH_LIM = 3'd6;
	localparam logic [2:0] REG_CRC_POLY  = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        message_ok;
		logic [4:0]  reason_code;
		logic        final_flag;
		logic [31:0] session_value;
		logic [31:0] epoch_value;
		logic [15:0] negotiation_value;
		logic [15:0] serial_value;
		logic [7:0]  start_index_value;
		logic [7:0]  entry_count;
		logic [15:0] bitmap_width;
	} out_item_t;

endpackage

@@ hdl/selective_ack_message_validator.sv @@
// Selective-ack message validator, top level.
// Depends on samv_pkg and selective_ack_message_validator_macros.svh.
//
// Usage: message bytes enter one per request on the in channel (valid/ready),
// wire order, last_byte set on the CRC trailer. Each non-final byte updates the CRC,
// header store and directory walker in the cycle it is accepted. Only the
// trailer makes a result: the verdict is registered and shown on the out
// channel (valid/ready) the cycle after the trailer is accepted.
// Throughput is one byte per cycle while no trailer is held off; the verdict
// comes from the output register alone. While a verdict waits on out_ready,
// non-final bytes are still taken; a trailer is held off until the waiting
// verdict leaves or is taken in the same cycle.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata, written while idle.
// Reset clears the message state (CRC to 0xff), the output valid flag and
// restores register defaults (slot capacity 4096, batch limit 255,
// polynomial 0x8c).
module selective_ack_message_validator #(
	parameter int unsigned SLOT_CAP_LIMIT  = 4096,
	parameter int unsigned MESSAGE_VERSION = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  samv_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output samv_pkg::out_item_t  out_data,
	input  logic                 cfg_wr_en,
	input  logic [2:0]           cfg_addr,
	input  logic [31:0]          cfg_wdata
);
	import samv_pkg::*;
`include "selective_ack_message_validator_macros.svh"

	localparam logic [16:0] SLOT_LIM = 17'(SLOT_CAP_LIMIT);
	localparam logic [7:0]  VERSION  = 8'(MESSAGE_VERSION);

	// configuration
	logic [31:0] exp_session_q, exp_epoch_q;
	logic [15:0] exp_negot_q, exp_serial_q, slot_cap_q;
	logic [7:0]  exp_start_q, batch_lim_q, crc_poly_q;

	// message state
	logic [16:0] pos_q;
	logic [7:0]  crc_q, prev_q;
	logic [7:0]  hdr_q [FIXED_LEN];
	logic [7:0]  ent_idx_q;
	logic [2:0]  ent_slot_q;
	logic [31:0] span_off_q;
	logic [16:0] span_tot_q;
	logic [4:0]  ent_err_q;

	logic        out_valid_q;
	out_item_t   out_q;

	logic        accept, in_last;
	logic [7:0]  b;

	assign in_ready = !out_valid_q || out_ready || !in_data.last_byte;
	assign accept   = in_valid && in_ready;
	assign b        = in_data.data_byte;
	assign in_last  = in_data.last_byte;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_session_q <= '0;
			exp_epoch_q   <= '0;
			exp_negot_q   <= '0;
			exp_serial_q  <= '0;
			exp_start_q   <= '0;
			slot_cap_q    <= 16'd4096;
			batch_lim_q   <= 8'd255;
			crc_poly_q    <= 8'd140;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_SESSION:   exp_session_q <= cfg_wdata;
				REG_EPOCH:     exp_epoch_q   <= cfg_wdata;
				REG_NEGOT:     exp_negot_q   <= cfg_wdata[15:0];
				REG_SERIAL:    exp_serial_q  <= cfg_wdata[15:0];
				REG_START:     exp_start_q   <= cfg_wdata[7:0];
				REG_SLOT_CAP:  slot_cap_q    <= cfg_wdata[15:0];
				REG_BATCH_LIM: batch_lim_q   <= cfg_wdata[7:0];
				REG_CRC_POLY:  crc_poly_q    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// CRC over one byte, reflected
	logic [7:0] crc_next;
	always_comb begin
		crc_next = crc_q ^ b;
		for (int i = 0; i < 8; i++) begin
			crc_next = crc_next[0] ? ((crc_next >> 1) ^ crc_poly_q) : (crc_next >> 1);
		end
	end

	// directory walker
	logic [7:0]  count;
	logic [7:0]  nidx;
	logic [2:0]  nslot;
	logic [31:0] noff;
	logic [16:0] ntot;
	logic [4:0]  nerr;
	logic [17:0] tot_sum;
	logic        walk;

	assign count = hdr_q[19];
	assign walk  = (pos_q >= 17'(FIXED_LEN)) && (ent_err_q == RSN_OK) && (ent_idx_q < count);

	always_comb begin
		nidx    = ent_idx_q;
		nslot   = ent_slot_q;
		noff    = span_off_q;
		ntot    = span_tot_q;
		nerr    = ent_err_q;
		tot_sum = 18'(span_tot_q) + 18'(span_off_q[31:16]);
		if (walk) begin
			unique case (ent_slot_q)
				3'd0: begin
					if (b != ent_idx_q) nerr = RSN_INDEX;
					noff = '0;
				end
				3'd1: noff = {b, 24'd0};
				3'd2: begin
					noff = {span_off_q[31:24], b, 16'd0};
					if ({span_off_q[31:24], b} == 16'd0) nerr = RSN_SPAN_ZERO;
				end
				3'd3: noff = {span_off_q[31:16], b, 8'd0};
				default: begin
					noff = {span_off_q[31:8], b};
					if (17'({span_off_q[15:8], b}) != span_tot_q) begin
						nerr = RSN_OFFSET;
					end else begin
						ntot = tot_sum[16:0];
						if (tot_sum > 18'hffff) nerr = RSN_OVERFLOW;
					end
				end
			endcase
			if (ent_slot_q >= 3'd4) begin
				nslot = '0;
				nidx  = ent_idx_q + 8'd1;
			end else begin
				nslot = ent_slot_q + 3'd1;
			end
		end
	end

	// verdict
	logic [16:0] n;
	logic [15:0] hlen, mlen, width;
	logic [31:0] session, epoch;
	logic [17:0] calc_len;
	logic [15:0] hlen_exp;
	logic [7:0]  pad_mask;
	logic [4:0]  reason;
	out_item_t   verdict_d;

	assign n        = (pos_q < POS_SAT) ? pos_q + 17'd1 : POS_SAT;
	assign hlen     = {hdr_q[2], hdr_q[3]};
	assign mlen     = {hdr_q[4], hdr_q[5]};
	assign session  = {hdr_q[6], hdr_q[7], hdr_q[8], hdr_q[9]};
	assign epoch    = {hdr_q[10], hdr_q[11], hdr_q[12], hdr_q[13]};
	assign width    = {hdr_q[20], hdr_q[21]};
	assign hlen_exp = 16'(FIXED_LEN) + {6'd0, count, 2'd0} + {8'd0, count};
	assign calc_len = 18'(hlen) + 18'((17'(width) + 17'd7) >> 3) + 18'd1;
	assign pad_mask = 8'hff << width[2:0];

	always_comb begin
		priority if (n < 17'(FIXED_LEN + 1))                 reason = RSN_TRUNC;
		else if (hdr_q[0] != VERSION)                        reason = RSN_VERSION;
		else if ((hdr_q[1] & 8'hfe) != 8'd0)                 reason = RSN_FLAGS;
		else if (count == 8'd0 || count > batch_lim_q)       reason = RSN_COUNT;
		else if (hlen != hlen_exp)                           reason = RSN_HDR_LEN;
		else if (17'(mlen) != n)                             reason = RSN_MSG_LEN;
		else if (calc_len != 18'(n))                         reason = RSN_MSG_LEN;
		else if (b != crc_q)                                 reason = RSN_CRC;
		else if (ent_err_q != RSN_OK)                        reason = ent_err_q;
		else if (span_tot_q != 17'(width))                   reason = RSN_WIDTH;
		else if (slot_cap_q == 16'd0 || 17'(slot_cap_q) > SLOT_LIM
			|| span_tot_q > 17'(slot_cap_q))                 reason = RSN_SLOT_CAP;
		else if (width[2:0] != 3'd0 && (prev_q & pad_mask) != 8'd0)
		                                                     reason = RSN_PADDING;
		else if (epoch == 32'd0)                             reason = RSN_EPOCH_ZERO;
		else if (session != exp_session_q)                   reason = RSN_SESSION;
		else if (epoch != exp_epoch_q)                       reason = RSN_EPOCH;
		else if ({hdr_q[14], hdr_q[15]} != exp_negot_q)      reason = RSN_NEGOT;
		else if ({hdr_q[16], hdr_q[17]} != exp_serial_q)     reason = RSN_SERIAL;
		else if (hdr_q[18] != exp_start_q)                   reason = RSN_START;
		else                                                 reason = RSN_OK;
	end

	// decoded fields only go out on a clean message
	always_comb begin
		verdict_d = '0;
		verdict_d.reason_code = reason;
		if (reason == RSN_OK) begin
			verdict_d.message_ok        = 1'b1;
			verdict_d.final_flag        = hdr_q[1][0];
			verdict_d.session_value     = session;
			verdict_d.epoch_value       = epoch;
			verdict_d.negotiation_value = {hdr_q[14], hdr_q[15]};
			verdict_d.serial_value      = {hdr_q[16], hdr_q[17]};
			verdict_d.start_index_value = hdr_q[18];
			verdict_d.entry_count       = count;
			verdict_d.bitmap_width      = width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			crc_q      <= 8'hff;
			prev_q     <= '0;
			ent_idx_q  <= '0;
			ent_slot_q <= '0;
			span_off_q <= '0;
			span_tot_q <= '0;
			ent_err_q  <= RSN_OK;
		end else if (accept) begin
			if (in_last) begin
				pos_q      <= '0;
				crc_q      <= 8'hff;
				prev_q     <= '0;
				ent_idx_q  <= '0;
				ent_slot_q <= '0;
				span_off_q <= '0;
				span_tot_q <= '0;
				ent_err_q  <= RSN_OK;
			end else begin
				if (pos_q < POS_SAT) pos_q <= pos_q + 17'd1;
				crc_q      <= crc_next;
				prev_q     <= b;
				ent_idx_q  <= nidx;
				ent_slot_q <= nslot;
				span_off_q <= noff;
				span_tot_q <= ntot;
				ent_err_q  <= nerr;
			end
		end
	end

	// header store: the first FIXED_LEN message bytes, written as they are accepted
	always_ff @(posedge clk) begin
		if (accept && !in_last && pos_q < 17'(FIXED_LEN)) begin
			hdr_q[pos_q[4:0]] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && in_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_last) begin
			out_q <= verdict_d;
		end
	end

	`SAMV_ASSERT(a_ok_matches_reason, !out_valid_q || (out_q.message_ok == (out_q.reason_code == RSN_OK)), "message_ok disagrees with reason")
	`SAMV_ASSERT(a_fail_clears_fields, !out_valid_q || out_q.message_ok || (out_q.session_value == 32'd0 && out_q.entry_count == 8'd0 && out_q.bitmap_width == 16'd0), "failed verdict carries decoded fields")
	`SAMV_ASSERT_NEXT(a_trailer_clears, accept && in_last, pos_q == 17'd0 && crc_q == 8'hff && ent_err_q == RSN_OK, "message state not cleared after trailer")
	`SAMV_ASSERT(a_pos_saturates, pos_q <= POS_SAT, "byte counter past saturation")
	`SAMV_ASSERT_NEXT(a_verdict_follows_trailer, accept && in_last, out_valid_q, "no verdict after trailer")

endmodule

@@ test/tb_selective_ack_message_validator.sv @@
// Self-checking testbench for selective_ack_message_validator.
// Streams generated messages (good ones and broken ones) and checks each verdict.
// Depends on samv_pkg and the validator RTL.
`timescale 1ns / 1ps

module tb_selective_ack_message_validator;
	import samv_pkg::*;

	localparam int unsigned CAP_LIMIT = 4096;
	localparam int LIMIT_CYCLES = 3000000;

	typedef enum int {
		MK_GOOD, MK_NOISE, MK_TRUNC, MK_VERSION, MK_FLAGS, MK_COUNT, MK_HDR, MK_LEN,
		MK_CRC, MK_INDEX, MK_SPAN0, MK_OFFSET, MK_OVERFLOW, MK_WIDTH, MK_PAD,
		MK_EPOCH0, MK_BIND
	} msg_kind_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;

	selective_ack_message_validator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register mirror
	logic [31:0] cfg_session = '0, cfg_epoch = '0;
	logic [15:0] cfg_negot = '0, cfg_serial = '0, cfg_slot = 16'd4096;
	logic [7:0]  cfg_start = '0, cfg_batch = 8'd255, cfg_poly = 8'h8c;

	// message state of the predictor
	int unsigned  pos;
	logic [7:0]   crc_acc;
	logic [7:0]   prev_b;
	logic [7:0]   hdr [FIXED_LEN];
	int unsigned  ent_idx, ent_slot, span_sum;
	logic [31:0]  span_off;
	logic [4:0]   dir_err;

	in_item_t  bytes_pending [$];
	out_item_t verdicts_due [$];
	int        errors = 0;
	int        bytes_queued = 0;
	int        msgs_queued = 0;
	int        hold_req = 0;

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [7:0] crc_step(logic [7:0] c, logic [7:0] b, logic [7:0] poly);
		logic [7:0] r;
		r = c ^ b;
		for (int i = 0; i < 8; i++)
			r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
		return r;
	endfunction

	task automatic clear_message();
		pos = 0;
		crc_acc = 8'hff;
		prev_b = '0;
		foreach (hdr[i]) hdr[i] = '0;
		ent_idx = 0;
		ent_slot = 0;
		span_off = '0;
		span_sum = 0;
		dir_err = RSN_OK;
	endtask

	task automatic walk_entry(logic [7:0] b);
		if (dir_err != RSN_OK || ent_idx >= hdr[19]) return;
		case (ent_slot)
			0: begin
				if (b != ent_idx) dir_err = RSN_INDEX;
				span_off = '0;
			end
			1: span_off = {b, 24'd0};
			2: begin
				span_off |= {8'd0, b, 16'd0};
				if (span_off[31:16] == 16'd0) dir_err = RSN_SPAN_ZERO;
			end
			3: span_off |= {16'd0, b, 8'd0};
			default: begin
				span_off |= {24'd0, b};
				if (span_off[15:0] != span_sum) begin
					dir_err = RSN_OFFSET;
				end else begin
					span_sum += span_off[31:16];
					if (span_sum > 65535) dir_err = RSN_OVERFLOW;
				end
			end
		endcase
		if (ent_slot >= 4) begin
			ent_slot = 0;
			ent_idx++;
		end else begin
			ent_slot++;
		end
	endtask

	function automatic logic [4:0] judge(logic [7:0] trailer, int unsigned n);
		int unsigned cnt, hlen, wid, used;
		if (n < FIXED_LEN + 1) return RSN_TRUNC;
		if (hdr[0] != 8'd1) return RSN_VERSION;
		if ((hdr[1] & 8'hfe) != 0) return RSN_FLAGS;
		cnt = hdr[19];
		hlen = {hdr[2], hdr[3]};
		wid = {hdr[20], hdr[21]};
		if (cnt == 0 || cnt > cfg_batch) return RSN_COUNT;
		if (hlen != FIXED_LEN + 5 * cnt) return RSN_HDR_LEN;
		if ({hdr[4], hdr[5]} != n) return RSN_MSG_LEN;
		if (hlen + (wid + 7) / 8 + 1 != n) return RSN_MSG_LEN;
		if (trailer != crc_acc) return RSN_CRC;
		if (dir_err != RSN_OK) return dir_err;
		if (span_sum != wid) return RSN_WIDTH;
		if (cfg_slot == 0 || cfg_slot > CAP_LIMIT || span_sum > cfg_slot) return RSN_SLOT_CAP;
		if ((wid & 7) != 0) begin
			used = (1 << (wid & 7)) - 1;
			if ((prev_b & ~used & 8'hff) != 0) return RSN_PADDING;
		end
		if ({hdr[10], hdr[11], hdr[12], hdr[13]} == 32'd0) return RSN_EPOCH_ZERO;
		if ({hdr[6], hdr[7], hdr[8], hdr[9]} != cfg_session) return RSN_SESSION;
		if ({hdr[10], hdr[11], hdr[12], hdr[13]} != cfg_epoch) return RSN_EPOCH;
		if ({hdr[14], hdr[15]} != cfg_negot) return RSN_NEGOT;
		if ({hdr[16], hdr[17]} != cfg_serial) return RSN_SERIAL;
		if (hdr[18] != cfg_start) return RSN_START;
		return RSN_OK;
	endfunction

	task automatic absorb_byte(in_item_t it);
		out_item_t v;
		int unsigned n;
		if (!it.last_byte) begin
			if (pos < FIXED_LEN) hdr[pos] = it.data_byte;
			else walk_entry(it.data_byte);
			crc_acc = crc_step(crc_acc, it.data_byte, cfg_poly);
			prev_b = it.data_byte;
			if (pos < POS_SAT) pos++;
		end else begin
			n = (pos < POS_SAT) ? pos + 1 : POS_SAT;
			v = '0;
			v.reason_code = judge(it.data_byte, n);
			if (v.reason_code == RSN_OK) begin
				v.message_ok = 1'b1;
				v.final_flag = hdr[1][0];
				v.session_value = {hdr[6], hdr[7], hdr[8], hdr[9]};
				v.epoch_value = {hdr[10], hdr[11], hdr[12], hdr[13]};
				v.negotiation_value = {hdr[14], hdr[15]};
				v.serial_value = {hdr[16], hdr[17]};
				v.start_index_value = hdr[18];
				v.entry_count = hdr[19];
				v.bitmap_width = {hdr[20], hdr[21]};
			end
			verdicts_due = {verdicts_due, v};
			clear_message();
		end
	endtask

	task automatic push_bytes(logic [7:0] m [$], logic [7:0] trailer);
		in_item_t it;
		foreach (m[i]) begin
			it.data_byte = m[i];
			it.last_byte = 1'b0;
			bytes_pending = {bytes_pending, it};
		end
		it.data_byte = trailer;
		it.last_byte = 1'b1;
		bytes_pending = {bytes_pending, it};
		bytes_queued += m.size() + 1;
		msgs_queued++;
	endtask

	// builds a well-formed message for the current registers, then breaks it as asked
	task automatic queue_message(msg_kind_e kind, int count, int span_max);
		logic [7:0]  m [$];
		int          spans [256];
		int unsigned sum, width, hlen, nbm, total, off, r, last;
		logic [7:0]  c;
		if (kind == MK_OVERFLOW && count < 2) count = 2;
		sum = 0;
		for (int i = 0; i < count; i++) begin
			spans[i] = $urandom_range(1, span_max);
			sum += spans[i];
		end
		if (kind == MK_OVERFLOW) begin
			spans[0] = 65535;
			spans[1] = $urandom_range(1, 200);
		end
		width = sum & 16'hffff;
		if (kind == MK_OVERFLOW) width = $urandom_range(1, 64);
		if (kind == MK_WIDTH) width = ($urandom_range(0, 1)) ? sum + $urandom_range(1, 9) : 0;
		hlen = FIXED_LEN + 5 * count;
		nbm = (width + 7) / 8;
		total = hlen + nbm + 1;
		m = {m, 8'd1, 8'($urandom_range(0, 1))};
		m = {m, hlen[15:8], hlen[7:0], total[15:8], total[7:0]};
		for (int i = 3; i >= 0; i--) m = {m, cfg_session[8*i +: 8]};
		for (int i = 3; i >= 0; i--) m = {m, cfg_epoch[8*i +: 8]};
		m = {m, cfg_negot[15:8], cfg_negot[7:0], cfg_serial[15:8], cfg_serial[7:0]};
		m = {m, cfg_start, 8'(count), width[15:8], width[7:0]};
		off = 0;
		for (int i = 0; i < count; i++) begin
			m = {m, 8'(i), 8'(spans[i] >> 8), 8'(spans[i]), off[15:8], off[7:0]};
			off = (off + spans[i]) & 16'hffff;
		end
		for (int j = 0; j < nbm; j++) m = {m, 8'($urandom)};
		last = m.size() - 1;
		if ((width & 7) != 0) m[last] &= 8'((1 << (width & 7)) - 1);
		r = $urandom_range(0, count - 1);
		case (kind)
			MK_NOISE:   m[$urandom_range(0, last)] ^= 8'(1 << $urandom_range(0, 7));
			MK_VERSION: m[0] = ($urandom_range(0, 1)) ? 8'd0 : 8'($urandom_range(2, 255));
			MK_FLAGS:   m[1] |= 8'(1 << $urandom_range(1, 7));
			MK_COUNT:   m[19] = ($urandom_range(0, 1)) ? 8'd0 : 8'(cfg_batch + 1);
			MK_HDR:     m[3] ^= 8'($urandom_range(1, 255));
			MK_LEN:     m[5] ^= 8'($urandom_range(1, 255));
			MK_INDEX:   m[22 + 5 * r] ^= 8'($urandom_range(1, 255));
			MK_SPAN0: begin
				m[23 + 5 * r] = 8'd0;
				m[24 + 5 * r] = 8'd0;
			end
			MK_OFFSET:  m[25 + 5 * r + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
			MK_PAD: begin
				if ((width & 7) != 0) m[last] |= 8'(1 << $urandom_range(width & 7, 7));
				else m[last] ^= 8'($urandom_range(1, 255));
			end
			MK_EPOCH0:  for (int i = 10; i < 14; i++) m[i] = 8'd0;
			MK_BIND:    m[$urandom_range(6, 18)] ^= 8'($urandom_range(1, 255));
			MK_TRUNC: begin
				m.delete();
				r = $urandom_range(0, FIXED_LEN - 1);
				for (int i = 0; i < r; i++) m = {m, 8'($urandom)};
			end
			default: ;
		endcase
		c = 8'hff;
		foreach (m[i]) c = crc_step(c, m[i], cfg_poly);
		if (kind == MK_CRC) c ^= 8'($urandom_range(1, 255));
		push_bytes(m, c);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (bytes_pending.size() != 0 || in_valid || verdicts_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		case (addr)
			REG_SESSION:   cfg_session = value;
			REG_EPOCH:     cfg_epoch = value;
			REG_NEGOT:     cfg_negot = value[15:0];
			REG_SERIAL:    cfg_serial = value[15:0];
			REG_START:     cfg_start = value[7:0];
			REG_SLOT_CAP:  cfg_slot = value[15:0];
			REG_BATCH_LIM: cfg_batch = value[7:0];
			default:       cfg_poly = value[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(logic [31:0] sess, logic [31:0] ep, logic [15:0] ng,
			logic [15:0] sr, logic [7:0] st, logic [15:0] slot, logic [7:0] lim,
			logic [7:0] poly);
		write_reg(REG_SESSION, sess);
		write_reg(REG_EPOCH, ep);
		write_reg(REG_NEGOT, {16'd0, ng});
		write_reg(REG_SERIAL, {16'd0, sr});
		write_reg(REG_START, {24'd0, st});
		write_reg(REG_SLOT_CAP, {16'd0, slot});
		write_reg(REG_BATCH_LIM, {24'd0, lim});
		write_reg(REG_CRC_POLY, {24'd0, poly});
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(int byte_goal);
		int start_bytes, start_msgs, lim, cnt;
		msg_kind_e kind;
		start_bytes = bytes_queued;
		start_msgs = msgs_queued;
		lim = (cfg_batch == 0) ? 1 : ((cfg_batch < 4) ? cfg_batch : 4);
		while (bytes_queued - start_bytes < byte_goal || msgs_queued - start_msgs < 3) begin
			kind = ($urandom_range(0, 1)) ? MK_GOOD : msg_kind_e'($urandom_range(1, MK_BIND));
			cnt = $urandom_range(1, lim);
			if ($urandom_range(0, 40) == 0) queue_message(kind, 2, 512);
			else queue_message(kind, cnt, 10);
		end
	endtask

	initial begin
		clear_message();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind of breakage on reset defaults, then the edges
		for (int k = MK_GOOD; k <= MK_BIND; k++) queue_message(msg_kind_e'(k), 2, 8);
		queue_message(MK_GOOD, 40, 1);
		queue_message(MK_GOOD, 2, 512);
		wait_idle();

		apply_setting($urandom, $urandom | 32'd1, 16'($urandom), 16'($urandom),
			8'($urandom), 16'd4096, 8'd255, 8'h8c);
		hold_req++;
		random_phase(100);
		wait_idle();

		apply_setting(32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 8'hff,
			16'd4096, 8'd255, 8'hff);
		random_phase(100);
		wait_idle();

		apply_setting(32'd0, 32'd0, 16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0);
		random_phase(100);
		wait_idle();

		apply_setting($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
			($urandom_range(0, 1)) ? 16'hffff : 16'd4097, 8'd1, 8'($urandom));
		random_phase(100);
		wait_idle();

		apply_setting($urandom, $urandom | 32'd1, 16'($urandom), 16'($urandom),
			8'($urandom), 16'($urandom_range(1, 24)), 8'($urandom_range(2, 255)),
			8'($urandom));
		hold_req++;
		random_phase(150);
		wait_idle();

		repeat (5) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	// sender: bursts with gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		logic taken, nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			taken = in_valid && in_ready;
			if (taken) absorb_byte(in_data);
			nv = in_valid && !taken;
			if (!in_valid || taken) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (bytes_pending.size() != 0) begin
					in_data <= bytes_pending.pop_front();
					nv = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_valid <= nv;
		end
	end

	// receiver: stall pattern picked at random from three modes, plus long hold-offs
	int hold_ack = 0, hold_left = 0, mode_cycles = 0, rx_mode = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_cycles == 0) begin
				rx_mode = $urandom_range(0, 2);
				mode_cycles = 50;
			end
			mode_cycles--;
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch("verdict with none outstanding");
			end else begin
				want = verdicts_due.pop_front();
				check_field("message_ok", out_data.message_ok, want.message_ok);
				check_field("reason_code", out_data.reason_code, want.reason_code);
				check_field("final_flag", out_data.final_flag, want.final_flag);
				check_field("session_value", out_data.session_value, want.session_value);
				check_field("epoch_value", out_data.epoch_value, want.epoch_value);
				check_field("negotiation_value", out_data.negotiation_value,
					want.negotiation_value);
				check_field("serial_value", out_data.serial_value, want.serial_value);
				check_field("start_index_value", out_data.start_index_value,
					want.start_index_value);
				check_field("entry_count", out_data.entry_count, want.entry_count);
				check_field("bitmap_width", out_data.bitmap_width, want.bitmap_width);
			end
		end
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
